// ===== rtl/core/dispense_valve_safety_controller_defines.svh =====
// assertion macros shared by the dispense valve controller modules
// needs a clock named aclk and an active-low reset named aresetn in scope
`ifndef DISPENSE_VALVE_SAFETY_CONTROLLER_DEFINES_SVH
`define DISPENSE_VALVE_SAFETY_CONTROLLER_DEFINES_SVH

// implication checked on the same edge
`define DVSC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dvsc check failed");

// implication checked on the following edge
`define DVSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dvsc check failed");

`endif

// ===== rtl/core/dvsc_pkg.sv =====
// types, codes and helper functions for the dispense valve controller
// used by dvsc_front, dvsc_back and the top level
package dvsc_pkg;

    localparam int IN_BYTES  = 15;
    localparam int OUT_BYTES = 15;

    localparam logic [31:0] MIN_TIME_SEC  = 32'd1;
    localparam logic [31:0] MAX_TIME_SEC  = 32'd3600;
    localparam logic [31:0] MIN_VOLUME_ML = 32'd10;
    localparam logic [31:0] MAX_VOLUME_ML = 32'd100000;

    localparam logic [31:0] SEC_SAT_LIMIT = 32'd4294967;
    localparam logic [41:0] MS_PER_SEC    = 42'd1000;
    localparam logic [63:0] INV_1000      = 64'd274877907;
    localparam int          INV_SHIFT     = 38;
    localparam logic [22:0] DUR_MAX       = 23'd65535;

    localparam logic [3:0] CMD_TICK    = 4'd0;
    localparam logic [3:0] CMD_REQUEST = 4'd1;
    localparam logic [3:0] CMD_CONFIRM = 4'd2;
    localparam logic [3:0] CMD_START   = 4'd3;
    localparam logic [3:0] CMD_ADJUST  = 4'd4;
    localparam logic [3:0] CMD_CANCEL  = 4'd5;
    localparam logic [3:0] CMD_STOP    = 4'd6;
    localparam logic [3:0] CMD_PAUSE   = 4'd7;
    localparam logic [3:0] CMD_ADD     = 4'd8;
    localparam logic [3:0] CMD_NOP     = 4'd15;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_CONFIRM = 3'd1;
    localparam logic [2:0] PH_RUN     = 3'd2;
    localparam logic [2:0] PH_PAUSE   = 3'd3;
    localparam logic [2:0] PH_ERROR   = 3'd4;

    localparam logic [2:0] OC_DONE     = 3'd0;
    localparam logic [2:0] OC_USER     = 3'd1;
    localparam logic [2:0] OC_PAUSE_TO = 3'd2;
    localparam logic [2:0] OC_SAFETY   = 3'd3;
    localparam logic [2:0] OC_FLOW     = 3'd4;

    localparam logic [2:0] REG_CONFIRM_TO  = 3'd0;
    localparam logic [2:0] REG_PAUSE_TO    = 3'd1;
    localparam logic [2:0] REG_MAX_RUN     = 3'd2;
    localparam logic [2:0] REG_MAX_VOLUME  = 3'd3;
    localparam logic [2:0] REG_OVERFLOW    = 3'd4;
    localparam logic [2:0] REG_NO_FLOW_TO  = 3'd5;
    localparam logic [2:0] REG_HIGH_FLOW   = 3'd6;
    localparam logic [2:0] REG_HIGH_DUR    = 3'd7;

    typedef struct packed {
        logic [15:0] confirm_timeout_sec;
        logic [15:0] pause_timeout_sec;
        logic [15:0] max_run_sec;
        logic [31:0] max_volume_ml;
        logic [7:0]  overflow_percent;
        logic [15:0] no_flow_timeout_sec;
        logic [15:0] high_flow_threshold;
        logic [15:0] high_flow_duration_sec;
    } cfg_t;

    typedef struct packed {
        logic [3:0]         cmd;
        logic [31:0]        now_ms;
        logic [15:0]        flow;
        logic [15:0]        add;
        logic               target_is_time;
        logic [31:0]        req_target;
        logic signed [15:0] delta;
    } item_t;

    typedef struct packed {
        logic        accepted;
        logic [2:0]  run_state;
        logic        valve_on;
        logic [31:0] volume;
        logic [31:0] elapsed_ms;
        logic [2:0]  outcome;
        logic        finished;
        logic [31:0] target;
        logic        is_time;
    } res_t;

    // seconds to milliseconds, saturating
    function automatic logic [31:0] to_ms(input logic [31:0] s);
        logic [41:0] p;
        p = {10'd0, s} * MS_PER_SEC;
        return (s > SEC_SAT_LIMIT) ? 32'hFFFF_FFFF : p[31:0];
    endfunction

    function automatic logic [31:0] clamp_target(input logic is_time,
                                                 input logic signed [33:0] v,
                                                 input logic [31:0] max_vol);
        logic signed [33:0] lo;
        logic signed [33:0] hi;
        logic signed [33:0] r;
        lo = is_time ? $signed({2'b00, MIN_TIME_SEC}) : $signed({2'b00, MIN_VOLUME_ML});
        if (is_time) begin
            hi = $signed({2'b00, MAX_TIME_SEC});
        end else if (max_vol < MAX_VOLUME_ML) begin
            hi = $signed({2'b00, max_vol});
        end else begin
            hi = $signed({2'b00, MAX_VOLUME_ML});
        end
        r = v;
        if (r < lo) r = lo;
        if (r > hi) r = hi;
        return r[31:0];
    endfunction

endpackage

// ===== rtl/core/dvsc_front.sv =====
// front end: unpacks and classifies commands, clamps request targets,
// and holds them in a two-entry queue; depends on dvsc_pkg
module dvsc_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [8*dvsc_pkg::IN_BYTES-1:0] s_tdata,
    input  logic [31:0]               max_volume_ml,
    output logic                      q_valid,
    output dvsc_pkg::item_t           q_item,
    input  logic                      q_pop
);
`include "dispense_valve_safety_controller_defines.svh"

    dvsc_pkg::item_t in_item;
    dvsc_pkg::item_t mem_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    logic            push;
    logic [3:0]      mode;

    assign mode = s_tdata[3:0];

    always_comb begin
        in_item.cmd            = (mode inside {[dvsc_pkg::CMD_TICK:dvsc_pkg::CMD_ADD]})
                                 ? mode : dvsc_pkg::CMD_NOP;
        in_item.now_ms         = s_tdata[35:4];
        in_item.flow           = s_tdata[51:36];
        in_item.add            = s_tdata[67:52];
        in_item.target_is_time = s_tdata[68];
        in_item.req_target     = dvsc_pkg::clamp_target(s_tdata[68],
                                     $signed({2'b00, s_tdata[100:69]}), max_volume_ml);
        in_item.delta          = $signed(s_tdata[116:101]);
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `DVSC_ASSERT_SAME(a_count_bound, 1'b1, count_reg != 2'd3)
    `DVSC_ASSERT_SAME(a_pop_needs_data, q_pop, count_reg != 2'd0)
    `DVSC_ASSERT_NEXT(a_push_grows, push && !q_pop, count_reg == $past(count_reg) + 2'd1)

endmodule

// ===== rtl/core/dvsc_back.sv =====
// back end: run state machine, timers and safety checks, one item per cycle
// while no untaken result stalls it, with a registered result; depends on dvsc_pkg
module dvsc_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  dvsc_pkg::cfg_t    cfg,
    input  logic              q_valid,
    input  dvsc_pkg::item_t   q_item,
    output logic              q_pop,
    output logic              res_valid,
    output dvsc_pkg::res_t    res,
    input  logic              res_ready
);
`include "dispense_valve_safety_controller_defines.svh"

    logic [2:0]  phase_reg, phase_next;
    logic        valve_reg, valve_next;
    logic [31:0] confirm_begin_reg, confirm_begin_next;
    logic [31:0] run_begin_reg, run_begin_next;
    logic [31:0] pause_begin_reg, pause_begin_next;
    logic [31:0] paused_sum_reg, paused_sum_next;
    logic [31:0] volume_reg, volume_next;
    logic [31:0] lf_volume_reg, lf_volume_next;
    logic [31:0] lf_time_reg, lf_time_next;
    logic        kind_reg, kind_next;
    logic [31:0] target_reg, target_next;
    logic        hf_active_reg, hf_active_next;
    logic [31:0] hf_begin_reg, hf_begin_next;
    logic [31:0] elapsed_ms_reg, elapsed_ms_next;
    logic [2:0]  outcome_reg, outcome_next;
    logic        res_valid_reg;
    dvsc_pkg::res_t res_reg, res_next;

    logic [31:0] now;
    logic [31:0] run_t, pause_t, paused_tot, act;
    logic [32:0] vol_sum;
    logic [40:0] ovf_lhs, ovf_rhs;
    logic [31:0] lft_eff;
    logic [31:0] adj_target;
    logic        acc, fin, ended;

    assign q_pop     = q_valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign now       = q_item.now_ms;

    always_comb begin
        run_t      = now - run_begin_reg;
        pause_t    = now - pause_begin_reg;
        paused_tot = (phase_reg == dvsc_pkg::PH_PAUSE) ? paused_sum_reg + pause_t
                                                       : paused_sum_reg;
        act        = (run_t > paused_tot) ? run_t - paused_tot : 32'd0;
        vol_sum    = {1'b0, volume_reg} + {17'd0, q_item.add};
        ovf_lhs    = {9'd0, volume_reg} * 41'd100;
        ovf_rhs    = {9'd0, target_reg} * ({33'd0, cfg.overflow_percent} + 41'd100);
        lft_eff    = (volume_reg > lf_volume_reg) ? now : lf_time_reg;
        adj_target = dvsc_pkg::clamp_target(kind_reg,
                         $signed({2'b00, target_reg}) + 34'(q_item.delta),
                         cfg.max_volume_ml);
    end

    always_comb begin
        phase_next         = phase_reg;
        valve_next         = valve_reg;
        confirm_begin_next = confirm_begin_reg;
        run_begin_next     = run_begin_reg;
        pause_begin_next   = pause_begin_reg;
        paused_sum_next    = paused_sum_reg;
        volume_next        = volume_reg;
        lf_volume_next     = lf_volume_reg;
        lf_time_next       = lf_time_reg;
        kind_next          = kind_reg;
        target_next        = target_reg;
        hf_active_next     = hf_active_reg;
        hf_begin_next      = hf_begin_reg;
        elapsed_ms_next    = elapsed_ms_reg;
        outcome_next       = outcome_reg;
        acc                = 1'b0;
        fin                = 1'b0;
        ended              = 1'b0;

        case (q_item.cmd)
            dvsc_pkg::CMD_TICK: begin
                if (phase_reg == dvsc_pkg::PH_RUN || phase_reg == dvsc_pkg::PH_PAUSE) begin
                    elapsed_ms_next = act;
                end
                if (phase_reg == dvsc_pkg::PH_CONFIRM &&
                    (now - confirm_begin_reg) >=
                    dvsc_pkg::to_ms({16'd0, cfg.confirm_timeout_sec})) begin
                    phase_next = dvsc_pkg::PH_IDLE;
                    valve_next = 1'b0;
                end else if (phase_reg == dvsc_pkg::PH_PAUSE &&
                             pause_t >= dvsc_pkg::to_ms({16'd0, cfg.pause_timeout_sec})) begin
                    ended        = 1'b1;
                    outcome_next = dvsc_pkg::OC_PAUSE_TO;
                    phase_next   = dvsc_pkg::PH_IDLE;
                end else if (phase_reg == dvsc_pkg::PH_RUN) begin
                    if (act >= dvsc_pkg::to_ms({16'd0, cfg.max_run_sec}) ||
                        volume_reg >= cfg.max_volume_ml) begin
                        ended        = 1'b1;
                        outcome_next = dvsc_pkg::OC_SAFETY;
                        phase_next   = dvsc_pkg::PH_ERROR;
                    end else if (!kind_reg && target_reg != 32'd0 && ovf_lhs > ovf_rhs) begin
                        ended        = 1'b1;
                        outcome_next = dvsc_pkg::OC_SAFETY;
                        phase_next   = dvsc_pkg::PH_ERROR;
                    end else begin
                        if (volume_reg > lf_volume_reg) begin
                            lf_volume_next = volume_reg;
                            lf_time_next   = now;
                        end
                        if ((now - lft_eff) >=
                            dvsc_pkg::to_ms({16'd0, cfg.no_flow_timeout_sec})) begin
                            ended        = 1'b1;
                            outcome_next = dvsc_pkg::OC_FLOW;
                            phase_next   = dvsc_pkg::PH_ERROR;
                        end else if (q_item.flow >= cfg.high_flow_threshold) begin
                            if (!hf_active_reg) begin
                                hf_active_next = 1'b1;
                                hf_begin_next  = now;
                            end else if ((now - hf_begin_reg) >=
                                dvsc_pkg::to_ms({16'd0, cfg.high_flow_duration_sec})) begin
                                ended        = 1'b1;
                                outcome_next = dvsc_pkg::OC_FLOW;
                                phase_next   = dvsc_pkg::PH_ERROR;
                            end
                        end else begin
                            hf_active_next = 1'b0;
                            hf_begin_next  = 32'd0;
                        end
                        if (!ended && target_reg != 32'd0 &&
                            ((!kind_reg && volume_reg >= target_reg) ||
                             (kind_reg && act >= dvsc_pkg::to_ms(target_reg)))) begin
                            ended        = 1'b1;
                            outcome_next = dvsc_pkg::OC_DONE;
                            phase_next   = dvsc_pkg::PH_IDLE;
                        end
                    end
                end
            end
            dvsc_pkg::CMD_REQUEST, dvsc_pkg::CMD_START: begin
                if (phase_reg == dvsc_pkg::PH_IDLE || phase_reg == dvsc_pkg::PH_ERROR) begin
                    acc                = 1'b1;
                    run_begin_next     = now;
                    pause_begin_next   = 32'd0;
                    paused_sum_next    = 32'd0;
                    volume_next        = 32'd0;
                    lf_volume_next     = 32'd0;
                    lf_time_next       = now;
                    hf_active_next     = 1'b0;
                    hf_begin_next      = 32'd0;
                    elapsed_ms_next    = 32'd0;
                    outcome_next       = dvsc_pkg::OC_DONE;
                    if (q_item.cmd == dvsc_pkg::CMD_REQUEST) begin
                        phase_next         = dvsc_pkg::PH_CONFIRM;
                        valve_next         = 1'b0;
                        confirm_begin_next = now;
                        kind_next          = q_item.target_is_time;
                        target_next        = q_item.req_target;
                    end else begin
                        phase_next         = dvsc_pkg::PH_RUN;
                        valve_next         = 1'b1;
                        confirm_begin_next = 32'd0;
                        kind_next          = 1'b0;
                        target_next        = 32'd0;
                    end
                end
            end
            dvsc_pkg::CMD_CONFIRM: begin
                if (phase_reg == dvsc_pkg::PH_CONFIRM) begin
                    acc              = 1'b1;
                    phase_next       = dvsc_pkg::PH_RUN;
                    valve_next       = 1'b1;
                    run_begin_next   = now;
                    pause_begin_next = 32'd0;
                    paused_sum_next  = 32'd0;
                    volume_next      = 32'd0;
                    lf_volume_next   = 32'd0;
                    lf_time_next     = now;
                    hf_active_next   = 1'b0;
                    hf_begin_next    = 32'd0;
                    elapsed_ms_next  = 32'd0;
                    outcome_next     = dvsc_pkg::OC_DONE;
                end
            end
            dvsc_pkg::CMD_ADJUST: begin
                if (phase_reg == dvsc_pkg::PH_CONFIRM && q_item.delta != 16'sd0 &&
                    adj_target != target_reg) begin
                    acc         = 1'b1;
                    target_next = adj_target;
                end
            end
            dvsc_pkg::CMD_CANCEL: begin
                if (phase_reg == dvsc_pkg::PH_CONFIRM || phase_reg == dvsc_pkg::PH_ERROR) begin
                    acc        = 1'b1;
                    phase_next = dvsc_pkg::PH_IDLE;
                    valve_next = 1'b0;
                end
            end
            dvsc_pkg::CMD_STOP: begin
                if (phase_reg == dvsc_pkg::PH_RUN || phase_reg == dvsc_pkg::PH_PAUSE) begin
                    acc          = 1'b1;
                    ended        = 1'b1;
                    outcome_next = dvsc_pkg::OC_USER;
                    phase_next   = dvsc_pkg::PH_IDLE;
                end else begin
                    acc        = (phase_reg != dvsc_pkg::PH_IDLE);
                    phase_next = dvsc_pkg::PH_IDLE;
                    valve_next = 1'b0;
                end
            end
            dvsc_pkg::CMD_PAUSE: begin
                if (phase_reg == dvsc_pkg::PH_RUN) begin
                    acc              = 1'b1;
                    phase_next       = dvsc_pkg::PH_PAUSE;
                    valve_next       = 1'b0;
                    pause_begin_next = now;
                end else if (phase_reg == dvsc_pkg::PH_PAUSE) begin
                    acc              = 1'b1;
                    phase_next       = dvsc_pkg::PH_RUN;
                    valve_next       = 1'b1;
                    paused_sum_next  = paused_sum_reg + pause_t;
                    pause_begin_next = 32'd0;
                    lf_time_next     = now;
                    lf_volume_next   = volume_reg;
                end
            end
            dvsc_pkg::CMD_ADD: begin
                if (phase_reg == dvsc_pkg::PH_RUN) begin
                    acc         = 1'b1;
                    volume_next = vol_sum[32] ? 32'hFFFF_FFFF : vol_sum[31:0];
                end
            end
            default: begin
            end
        endcase

        // common run ending
        if (ended) begin
            fin             = 1'b1;
            elapsed_ms_next = act;
            valve_next      = 1'b0;
            hf_active_next  = 1'b0;
            hf_begin_next   = 32'd0;
        end

        res_next.accepted   = acc;
        res_next.run_state  = phase_next;
        res_next.valve_on   = valve_next;
        res_next.volume     = volume_next;
        res_next.elapsed_ms = elapsed_ms_next;
        res_next.outcome    = outcome_next;
        res_next.finished   = fin;
        res_next.target     = target_next;
        res_next.is_time    = kind_next;
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= dvsc_pkg::PH_IDLE;
            valve_reg         <= 1'b0;
            confirm_begin_reg <= 32'd0;
            run_begin_reg     <= 32'd0;
            pause_begin_reg   <= 32'd0;
            paused_sum_reg    <= 32'd0;
            volume_reg        <= 32'd0;
            lf_volume_reg     <= 32'd0;
            lf_time_reg       <= 32'd0;
            kind_reg          <= 1'b0;
            target_reg        <= 32'd0;
            hf_active_reg     <= 1'b0;
            hf_begin_reg      <= 32'd0;
            elapsed_ms_reg    <= 32'd0;
            outcome_reg       <= dvsc_pkg::OC_DONE;
            res_valid_reg     <= 1'b0;
        end else begin
            if (q_pop) begin
                phase_reg         <= phase_next;
                valve_reg         <= valve_next;
                confirm_begin_reg <= confirm_begin_next;
                run_begin_reg     <= run_begin_next;
                pause_begin_reg   <= pause_begin_next;
                paused_sum_reg    <= paused_sum_next;
                volume_reg        <= volume_next;
                lf_volume_reg     <= lf_volume_next;
                lf_time_reg       <= lf_time_next;
                kind_reg          <= kind_next;
                target_reg        <= target_next;
                hf_active_reg     <= hf_active_next;
                hf_begin_reg      <= hf_begin_next;
                elapsed_ms_reg    <= elapsed_ms_next;
                outcome_reg       <= outcome_next;
            end
            if (q_pop) begin
                res_valid_reg <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    `DVSC_ASSERT_SAME(a_valve_only_running, valve_reg, phase_reg == dvsc_pkg::PH_RUN)
    `DVSC_ASSERT_NEXT(a_finish_closes_valve, q_pop && fin, !valve_reg && !res_reg.valve_on)
    `DVSC_ASSERT_NEXT(a_result_held, res_valid_reg && !res_ready, res_valid_reg && $stable(res_reg))

endmodule

// ===== rtl/core/dispense_valve_safety_controller.sv =====
// top level of the dispense valve safety controller: register file,
// front end queue and run engine; depends on dvsc_pkg, dvsc_front, dvsc_back
//
// Commands and ticks enter on the s_ stream, each carrying its own millisecond
// timestamp, and every item returns exactly one result on the m_ stream. The
// block takes one item per clock while the queue has room: the front end
// unpacks the command, maps unused mode codes to a no-op and clamps a request
// target, then parks it in a two-entry queue; the run engine retires one
// queued item per cycle into a result register while no untaken result holds
// it, so the input keeps flowing while a result waits to be taken, until the
// queue fills. Each item passes through the queue entry and then the result
// register. Seconds shown on the result are derived from stored milliseconds
// by a constant reciprocal multiply at the output. Limits are set through the
// APB-style port and should only be changed with no items in flight.
module dispense_valve_safety_controller (
    input  logic          aclk,
    input  logic          aresetn,
    // mode[3:0], now_ms[35:4], flow_ml_per_min[51:36], added_volume_ml[67:52],
    // target_is_time[68], target_amount[100:69], target_delta[116:101], zero fill
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [8*dvsc_pkg::IN_BYTES-1:0] s_tdata,
    // accepted[0], run_state[3:1], valve_on[4], volume_total_ml[36:5],
    // elapsed_sec[59:37], outcome[62:60], run_finished[63], duration_sec[79:64],
    // current_target[111:80], current_is_time[112], zero fill
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [8*dvsc_pkg::OUT_BYTES-1:0] m_tdata,
    // configuration port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    dvsc_pkg::cfg_t  cfg_reg;
    dvsc_pkg::item_t q_item;
    dvsc_pkg::res_t  res;
    logic            q_valid, q_pop;
    logic            cfg_wr;
    logic [2:0]      reg_idx;
    logic [63:0]     sec_prod;
    logic [22:0]     secs;
    logic [15:0]     duration;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    // register write, taken in the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.confirm_timeout_sec    <= 16'd30;
            cfg_reg.pause_timeout_sec      <= 16'd300;
            cfg_reg.max_run_sec            <= 16'd1800;
            cfg_reg.max_volume_ml          <= 32'd100000;
            cfg_reg.overflow_percent       <= 8'd20;
            cfg_reg.no_flow_timeout_sec    <= 16'd30;
            cfg_reg.high_flow_threshold    <= 16'd20000;
            cfg_reg.high_flow_duration_sec <= 16'd10;
        end else if (cfg_wr) begin
            case (reg_idx)
                dvsc_pkg::REG_CONFIRM_TO: cfg_reg.confirm_timeout_sec    <= pwdata[15:0];
                dvsc_pkg::REG_PAUSE_TO:   cfg_reg.pause_timeout_sec      <= pwdata[15:0];
                dvsc_pkg::REG_MAX_RUN:    cfg_reg.max_run_sec            <= pwdata[15:0];
                dvsc_pkg::REG_MAX_VOLUME: cfg_reg.max_volume_ml          <= pwdata;
                dvsc_pkg::REG_OVERFLOW:   cfg_reg.overflow_percent       <= pwdata[7:0];
                dvsc_pkg::REG_NO_FLOW_TO: cfg_reg.no_flow_timeout_sec    <= pwdata[15:0];
                dvsc_pkg::REG_HIGH_FLOW:  cfg_reg.high_flow_threshold    <= pwdata[15:0];
                dvsc_pkg::REG_HIGH_DUR:   cfg_reg.high_flow_duration_sec <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // register read back
    always_comb begin
        case (reg_idx)
            dvsc_pkg::REG_CONFIRM_TO: prdata = {16'd0, cfg_reg.confirm_timeout_sec};
            dvsc_pkg::REG_PAUSE_TO:   prdata = {16'd0, cfg_reg.pause_timeout_sec};
            dvsc_pkg::REG_MAX_RUN:    prdata = {16'd0, cfg_reg.max_run_sec};
            dvsc_pkg::REG_MAX_VOLUME: prdata = cfg_reg.max_volume_ml;
            dvsc_pkg::REG_OVERFLOW:   prdata = {24'd0, cfg_reg.overflow_percent};
            dvsc_pkg::REG_NO_FLOW_TO: prdata = {16'd0, cfg_reg.no_flow_timeout_sec};
            dvsc_pkg::REG_HIGH_FLOW:  prdata = {16'd0, cfg_reg.high_flow_threshold};
            dvsc_pkg::REG_HIGH_DUR:   prdata = {16'd0, cfg_reg.high_flow_duration_sec};
            default:                  prdata = 32'd0;
        endcase
    end

    // front end with command queue
    dvsc_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .max_volume_ml (cfg_reg.max_volume_ml),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    // run engine with result register
    dvsc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .res_valid (m_tvalid),
        .res       (res),
        .res_ready (m_tready)
    );

    // milliseconds to whole seconds, exact for any 32-bit value
    assign sec_prod = {32'd0, res.elapsed_ms} * dvsc_pkg::INV_1000;
    assign secs     = sec_prod[dvsc_pkg::INV_SHIFT +: 23];
    assign duration = !res.finished ? 16'd0 :
                      (secs > dvsc_pkg::DUR_MAX) ? 16'hFFFF : secs[15:0];

    assign m_tdata = {7'd0, res.is_time, res.target, duration, res.finished,
                      res.outcome, secs, res.volume, res.valve_on, res.run_state,
                      res.accepted};

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the dispense valve safety controller
// drives the s_ command stream and the apb port, checks every m_ result
// against a behavioural predictor; depends on dvsc_pkg and the rtl
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic [2:0]  run_state;
        logic        accepted;
        logic        valve_on;
        logic [31:0] volume;
        logic [22:0] elapsed;
        logic [2:0]  outcome;
        logic        finished;
        logic [15:0] duration;
        logic [31:0] target;
        logic        is_time;
    } status_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [119:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [119:0] m_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    dispense_valve_safety_controller uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor copy of limits and run state
    logic [31:0] lim_confirm, lim_pause, lim_run, lim_volume, lim_over;
    logic [31:0] lim_noflow, lim_hiflow, lim_hidur;
    logic [2:0]  p_phase;
    logic        p_valve, p_kind, p_hf_on;
    logic [31:0] p_conf_t0, p_run_t0, p_pause_t0, p_paused, p_vol;
    logic [31:0] p_flow_vol, p_flow_t, p_target, p_hf_t0, p_elapsed;
    logic [2:0]  p_outcome;
    logic        p_fin;
    logic [31:0] p_dur;

    status_t     expected_status[$];
    int          failures;
    int          sender_idle;   // percent of cycles the sender holds off
    int          receiver_idle; // percent of cycles the receiver stalls
    logic [31:0] clock_ms;      // running timestamp for generated requests

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #400ms;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [31:0] sec_to_ms(input logic [31:0] s);
        return (s > 32'd4294967) ? 32'hFFFF_FFFF : s * 32'd1000;
    endfunction

    function automatic logic [31:0] active_time(input logic [31:0] now);
        logic [31:0] p;
        logic [31:0] t;
        p = p_paused;
        t = now - p_run_t0;
        if (p_phase == dvsc_pkg::PH_PAUSE) p = p + (now - p_pause_t0);
        return (t > p) ? t - p : 32'd0;
    endfunction

    function automatic logic [31:0] limit_target(input logic is_time,
                                                 input longint v);
        longint lo;
        longint hi;
        lo = is_time ? 1 : 10;
        if (is_time) hi = 3600;
        else hi = (lim_volume < 100000) ? longint'(lim_volume) : 100000;
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return v[31:0];
    endfunction

    function automatic void close_run(input logic [31:0] now, input logic [2:0] oc,
                                      input logic [2:0] nxt);
        logic [31:0] secs;
        secs = active_time(now) / 32'd1000;
        p_fin = 1'b1;
        p_dur = (secs > 32'd65535) ? 32'd65535 : secs;
        p_outcome = oc;
        p_elapsed = secs;
        p_phase = nxt;
        p_valve = 1'b0;
        p_hf_on = 1'b0;
        p_hf_t0 = 32'd0;
    endfunction

    function automatic void open_counts(input logic [31:0] now);
        p_run_t0 = now;
        p_pause_t0 = 0;
        p_paused = 0;
        p_vol = 0;
        p_flow_vol = 0;
        p_flow_t = now;
        p_hf_on = 0;
        p_hf_t0 = 0;
        p_elapsed = 0;
        p_outcome = dvsc_pkg::OC_DONE;
    endfunction

    // safety checks while running; returns 1 when the run was ended
    function automatic bit run_guards(input logic [31:0] now, input logic [31:0] flow);
        logic [63:0] cap;
        if (active_time(now) >= sec_to_ms(lim_run) || p_vol >= lim_volume) begin
            close_run(now, dvsc_pkg::OC_SAFETY, dvsc_pkg::PH_ERROR);
            return 1;
        end
        if (!p_kind && p_target != 0) begin
            cap = (64'(p_target) * (64'd100 + 64'(lim_over))) / 64'd100;
            if (64'(p_vol) > cap) begin
                close_run(now, dvsc_pkg::OC_SAFETY, dvsc_pkg::PH_ERROR);
                return 1;
            end
        end
        if (p_vol > p_flow_vol) begin
            p_flow_vol = p_vol;
            p_flow_t = now;
        end
        if (now - p_flow_t >= sec_to_ms(lim_noflow)) begin
            close_run(now, dvsc_pkg::OC_FLOW, dvsc_pkg::PH_ERROR);
            return 1;
        end
        if (flow >= lim_hiflow) begin
            if (!p_hf_on) begin
                p_hf_on = 1;
                p_hf_t0 = now;
            end else if (now - p_hf_t0 >= sec_to_ms(lim_hidur)) begin
                close_run(now, dvsc_pkg::OC_FLOW, dvsc_pkg::PH_ERROR);
                return 1;
            end
        end else begin
            p_hf_on = 0;
            p_hf_t0 = 0;
        end
        return 0;
    endfunction

    function automatic void handle_tick(input logic [31:0] now, input logic [31:0] flow);
        if (p_phase == dvsc_pkg::PH_RUN || p_phase == dvsc_pkg::PH_PAUSE)
            p_elapsed = active_time(now) / 32'd1000;
        if (p_phase == dvsc_pkg::PH_CONFIRM && now - p_conf_t0 >= sec_to_ms(lim_confirm)) begin
            p_phase = dvsc_pkg::PH_IDLE;
            p_valve = 0;
        end else if (p_phase == dvsc_pkg::PH_PAUSE &&
                     now - p_pause_t0 >= sec_to_ms(lim_pause)) begin
            close_run(now, dvsc_pkg::OC_PAUSE_TO, dvsc_pkg::PH_IDLE);
        end else if (p_phase == dvsc_pkg::PH_RUN) begin
            if (!run_guards(now, flow) && p_target != 0) begin
                if (!p_kind && p_vol >= p_target)
                    close_run(now, dvsc_pkg::OC_DONE, dvsc_pkg::PH_IDLE);
                else if (p_kind && active_time(now) >= sec_to_ms(p_target))
                    close_run(now, dvsc_pkg::OC_DONE, dvsc_pkg::PH_IDLE);
            end
        end
    endfunction

    function automatic status_t predict_status(input logic [119:0] d);
        logic [3:0]  mode;
        logic [31:0] now, flow, add, amt, nt;
        logic        tkind;
        longint      delta;
        logic        acc;
        status_t     r;
        mode  = d[3:0];
        now   = d[35:4];
        flow  = {16'd0, d[51:36]};
        add   = {16'd0, d[67:52]};
        tkind = d[68];
        amt   = d[100:69];
        delta = longint'($signed(d[116:101]));
        acc   = 0;
        p_fin = 0;
        p_dur = 0;
        case (mode)
            dvsc_pkg::CMD_TICK: handle_tick(now, flow);
            dvsc_pkg::CMD_REQUEST: if (p_phase == dvsc_pkg::PH_IDLE ||
                                       p_phase == dvsc_pkg::PH_ERROR) begin
                p_phase = dvsc_pkg::PH_CONFIRM;
                p_valve = 0;
                p_conf_t0 = now;
                p_kind = tkind;
                p_target = limit_target(tkind, longint'(amt));
                open_counts(now);
                acc = 1;
            end
            dvsc_pkg::CMD_CONFIRM: if (p_phase == dvsc_pkg::PH_CONFIRM) begin
                p_phase = dvsc_pkg::PH_RUN;
                p_valve = 1;
                open_counts(now);
                acc = 1;
            end
            dvsc_pkg::CMD_START: if (p_phase == dvsc_pkg::PH_IDLE ||
                                     p_phase == dvsc_pkg::PH_ERROR) begin
                p_phase = dvsc_pkg::PH_RUN;
                p_valve = 1;
                p_kind = 0;
                p_target = 0;
                p_conf_t0 = 0;
                open_counts(now);
                acc = 1;
            end
            dvsc_pkg::CMD_ADJUST: if (p_phase == dvsc_pkg::PH_CONFIRM && delta != 0) begin
                nt = limit_target(p_kind, longint'(p_target) + delta);
                if (nt != p_target) begin
                    p_target = nt;
                    acc = 1;
                end
            end
            dvsc_pkg::CMD_CANCEL: if (p_phase == dvsc_pkg::PH_CONFIRM ||
                                      p_phase == dvsc_pkg::PH_ERROR) begin
                p_phase = dvsc_pkg::PH_IDLE;
                p_valve = 0;
                acc = 1;
            end
            dvsc_pkg::CMD_STOP: if (p_phase == dvsc_pkg::PH_RUN ||
                                    p_phase == dvsc_pkg::PH_PAUSE) begin
                close_run(now, dvsc_pkg::OC_USER, dvsc_pkg::PH_IDLE);
                acc = 1;
            end else begin
                if (p_phase != dvsc_pkg::PH_IDLE) acc = 1;
                p_phase = dvsc_pkg::PH_IDLE;
                p_valve = 0;
            end
            dvsc_pkg::CMD_PAUSE: if (p_phase == dvsc_pkg::PH_RUN) begin
                p_phase = dvsc_pkg::PH_PAUSE;
                p_valve = 0;
                p_pause_t0 = now;
                acc = 1;
            end else if (p_phase == dvsc_pkg::PH_PAUSE) begin
                p_phase = dvsc_pkg::PH_RUN;
                p_valve = 1;
                p_paused = p_paused + (now - p_pause_t0);
                p_pause_t0 = 0;
                p_flow_t = now;
                p_flow_vol = p_vol;
                acc = 1;
            end
            dvsc_pkg::CMD_ADD: if (p_phase == dvsc_pkg::PH_RUN) begin
                p_vol = (32'hFFFF_FFFF - p_vol < add) ? 32'hFFFF_FFFF : p_vol + add;
                acc = 1;
            end
            default: ;
        endcase
        r.accepted  = acc;
        r.run_state = p_phase;
        r.valve_on  = p_valve;
        r.volume    = p_vol;
        r.elapsed   = p_elapsed[22:0];
        r.outcome   = p_outcome;
        r.finished  = p_fin;
        r.duration  = p_dur[15:0];
        r.target    = p_target;
        r.is_time   = p_kind;
        return r;
    endfunction

    // receiver: random stall and one compare per accepted result
    always @(posedge aclk) begin : rx_check
        status_t want;
        status_t got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.accepted  = m_tdata[0];
                got.run_state = m_tdata[3:1];
                got.valve_on  = m_tdata[4];
                got.volume    = m_tdata[36:5];
                got.elapsed   = m_tdata[59:37];
                got.outcome   = m_tdata[62:60];
                got.finished  = m_tdata[63];
                got.duration  = m_tdata[79:64];
                got.target    = m_tdata[111:80];
                got.is_time   = m_tdata[112];
                if (expected_status.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    failures++;
                end else begin
                    want = expected_status.pop_front();
                    if (got !== want) begin
                        $display("%0t: result mismatch expected %p actual %p",
                                 $time, want, got);
                        failures++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= receiver_idle);
        end
    end

    // one apb write, setup then access; mirrored into the predictor limits
    task automatic write_limit(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            dvsc_pkg::REG_CONFIRM_TO: lim_confirm = {16'd0, val[15:0]};
            dvsc_pkg::REG_PAUSE_TO:   lim_pause   = {16'd0, val[15:0]};
            dvsc_pkg::REG_MAX_RUN:    lim_run     = {16'd0, val[15:0]};
            dvsc_pkg::REG_MAX_VOLUME: lim_volume  = val;
            dvsc_pkg::REG_OVERFLOW:   lim_over    = {24'd0, val[7:0]};
            dvsc_pkg::REG_NO_FLOW_TO: lim_noflow  = {16'd0, val[15:0]};
            dvsc_pkg::REG_HIGH_FLOW:  lim_hiflow  = {16'd0, val[15:0]};
            dvsc_pkg::REG_HIGH_DUR:   lim_hidur   = {16'd0, val[15:0]};
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // one request on the s_ stream; prediction is made at acceptance
    task automatic send_request(input logic [3:0] mode, input logic [31:0] now,
                                input logic [15:0] flow, input logic [15:0] add,
                                input logic kind, input logic [31:0] amt,
                                input logic [15:0] delta);
        logic [119:0] d;
        while ($urandom_range(99) < sender_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        d = {3'd0, delta, amt, kind, add, flow, now, mode};
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_status.push_back(predict_status(d));
    endtask

    task automatic drain_results();
        int n;
        n = 0;
        s_tvalid <= 1'b0;
        while (expected_status.size() != 0) @(posedge aclk);
        while (n < 20) begin
            @(posedge aclk);
            n++;
        end
    endtask

    // clock advance used by the random part, mostly small steps
    task automatic step_clock();
        case ($urandom_range(9))
            0:       clock_ms = clock_ms + $urandom;
            1, 2:    clock_ms = clock_ms + $urandom_range(60000);
            default: clock_ms = clock_ms + $urandom_range(3000);
        endcase
    endtask

    task automatic test_defaults_directed();
        send_request(dvsc_pkg::CMD_STOP, 32'd0, 0, 0, 0, 0, 0);
        send_request(dvsc_pkg::CMD_PAUSE, 32'd5, 0, 0, 0, 0, 0);
        send_request(dvsc_pkg::CMD_ADD, 32'd6, 0, 16'hFFFF, 0, 0, 0);
        send_request(4'd9, 32'd7, 16'hFFFF, 16'hFFFF, 1, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(dvsc_pkg::CMD_NOP, 32'd8, 0, 0, 0, 0, 0);
        send_request(dvsc_pkg::CMD_REQUEST, 32'd10, 0, 0, 0, 32'hFFFF_FFFF, 0);
        send_request(dvsc_pkg::CMD_ADJUST, 32'd11, 0, 0, 0, 0, 16'h8000);
        send_request(dvsc_pkg::CMD_ADJUST, 32'd12, 0, 0, 0, 0, 16'h7FFF);
        send_request(dvsc_pkg::CMD_ADJUST, 32'd13, 0, 0, 0, 0, 16'd0);
        send_request(dvsc_pkg::CMD_REQUEST, 32'd14, 0, 0, 1, 32'd0, 0);
        send_request(dvsc_pkg::CMD_CONFIRM, 32'd20, 0, 0, 0, 0, 0);
        send_request(dvsc_pkg::CMD_TICK, 32'd1500, 16'hFFFF, 0, 0, 0, 0);
        send_request(dvsc_pkg::CMD_PAUSE, 32'd1600, 0, 0, 0, 0, 0);
        send_request(dvsc_pkg::CMD_TICK, 32'd2000, 0, 0, 0, 0, 0);
        send_request(dvsc_pkg::CMD_PAUSE, 32'd4000, 0, 0, 0, 0, 0);
        send_request(dvsc_pkg::CMD_TICK, 32'd5000, 0, 0, 0, 0, 0);
        send_request(dvsc_pkg::CMD_START, 32'hFFFF_FF00, 0, 0, 0, 0, 0);
        send_request(dvsc_pkg::CMD_ADD, 32'hFFFF_FFF0, 0, 16'd40000, 0, 0, 0);
        send_request(dvsc_pkg::CMD_TICK, 32'd300, 16'd25000, 0, 0, 0, 0);
        send_request(dvsc_pkg::CMD_TICK, 32'd20000, 16'd25000, 0, 0, 0, 0);
        send_request(dvsc_pkg::CMD_CANCEL, 32'd20001, 0, 0, 0, 0, 0);
        send_request(dvsc_pkg::CMD_CANCEL, 32'd20002, 0, 0, 0, 0, 0);
        drain_results();
    endtask

    // well-formed runs with random content and occasional noise
    task automatic test_random_runs(input int count);
        int i;
        int k;
        logic [3:0] mode;
        i = 0;
        while (i < count) begin
            step_clock();
            k = $urandom_range(99);
            if (k < 10) mode = (p_phase == dvsc_pkg::PH_IDLE || p_phase == dvsc_pkg::PH_ERROR)
                               ? (($urandom_range(1) == 0) ? dvsc_pkg::CMD_REQUEST
                                                           : dvsc_pkg::CMD_START)
                               : dvsc_pkg::CMD_TICK;
            else if (k < 18) mode = dvsc_pkg::CMD_CONFIRM;
            else if (k < 24) mode = dvsc_pkg::CMD_ADJUST;
            else if (k < 27) mode = dvsc_pkg::CMD_CANCEL;
            else if (k < 31) mode = dvsc_pkg::CMD_STOP;
            else if (k < 36) mode = dvsc_pkg::CMD_PAUSE;
            else if (k < 60) mode = dvsc_pkg::CMD_ADD;
            else if (k < 97) mode = dvsc_pkg::CMD_TICK;
            else mode = 4'($urandom_range(15));
            send_request(mode, clock_ms,
                         ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(25000)),
                         ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2000)),
                         1'($urandom), ($urandom_range(1) == 0) ? $urandom
                                                                : $urandom_range(5000),
                         ($urandom_range(1) == 0) ? 16'($urandom)
                                                  : 16'($signed($urandom_range(400)) - 200));
            i++;
        end
        drain_results();
    endtask

    task automatic test_limit_settings();
        int j;
        for (j = 0; j < 8; j++) write_limit(3'(j), 32'd0);
        test_random_runs(60);
        for (j = 0; j < 8; j++) write_limit(3'(j), 32'hFFFF_FFFF);
        test_random_runs(60);
        for (j = 0; j < 8; j++) write_limit(3'(j), $urandom_range(120));
        write_limit(dvsc_pkg::REG_MAX_VOLUME, $urandom_range(200000));
        write_limit(dvsc_pkg::REG_HIGH_FLOW, $urandom_range(30000));
        test_random_runs(80);
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        failures = 0;
        sender_idle   = 0;
        receiver_idle = 0;
        clock_ms = 32'd0;
        lim_confirm = 30; lim_pause = 300; lim_run = 1800; lim_volume = 100000;
        lim_over = 20; lim_noflow = 30; lim_hiflow = 20000; lim_hidur = 10;
        p_phase = dvsc_pkg::PH_IDLE; p_valve = 0; p_kind = 0; p_conf_t0 = 0; p_target = 0;
        open_counts(32'd0);
        p_fin = 0; p_dur = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_defaults_directed();
        test_random_runs(150);
        sender_idle = 75;
        test_random_runs(100);
        sender_idle = 0;
        receiver_idle = 75;
        test_random_runs(100);
        sender_idle = 8;
        receiver_idle = 8;
        test_limit_settings();
        write_limit(dvsc_pkg::REG_CONFIRM_TO, 30);
        write_limit(dvsc_pkg::REG_PAUSE_TO, 300);
        write_limit(dvsc_pkg::REG_MAX_RUN, 1800);
        write_limit(dvsc_pkg::REG_MAX_VOLUME, 100000);
        write_limit(dvsc_pkg::REG_OVERFLOW, 20);
        write_limit(dvsc_pkg::REG_NO_FLOW_TO, 30);
        write_limit(dvsc_pkg::REG_HIGH_FLOW, 20000);
        write_limit(dvsc_pkg::REG_HIGH_DUR, 10);
        test_random_runs(150);

        if (failures == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
